// File: design/cldq_pkg.sv
`default_nettype none

package cldq_pkg;

  localparam int DEPTH    = 16;
  localparam int CYL_BITS = 16;
  localparam int PID_BITS = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int SLOT_W   = CYL_BITS + PID_BITS;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_KILL = 2'd2,
    CMD_NOP  = 2'd3
  } cldq_cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } cldq_status_e;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } cldq_state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] request_cylinder;
    logic [15:0] request_pid;
  } cldq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_pid;
    logic [15:0] out_cylinder;
    logic [4:0]  occupancy;
  } cldq_out_t;

  typedef struct packed {
    logic [CYL_BITS-1:0] cyl;
    logic [PID_BITS-1:0] pid;
  } cldq_slot_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    cldq_slot_t       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } cldq_ram_req_t;

  // Input cylinder taken modulo 2^CYL_BITS.
  function automatic logic [CYL_BITS-1:0] cyl_from_field(input logic [15:0] f);
    logic [CYL_BITS+15:0] t;
    t = {{CYL_BITS{1'b0}}, f};
    return t[CYL_BITS-1:0];
  endfunction

  function automatic logic [15:0] cyl_to_field(input logic [CYL_BITS-1:0] c);
    logic [CYL_BITS+15:0] t;
    t = {16'd0, c};
    return t[15:0];
  endfunction

  function automatic logic [4:0] count_to_field(input logic [CNT_W-1:0] c);
    logic [CNT_W+4:0] t;
    t = {5'd0, c};
    return t[4:0];
  endfunction

endpackage

`default_nettype wire

// File: design/cldq_slot_ram.sv
`default_nettype none

module cldq_slot_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/cldq_seq.sv
`default_nettype none

module cldq_seq (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire cldq_pkg::cldq_in_t      in_data,
  input  wire logic                    res_ok,
  output logic                         res_valid,
  output cldq_pkg::cldq_out_t          res_data,
  output cldq_pkg::cldq_ram_req_t      ram_req,
  input  wire cldq_pkg::cldq_slot_t    ram_rdata
);

  import cldq_pkg::*;

  cldq_state_e         state_r, state_nxt;
  cldq_cmd_e           op_r, op_nxt;
  logic [CYL_BITS-1:0] cyl_r, cyl_nxt;
  logic [PID_BITS-1:0] pid_r, pid_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  cldq_slot_t          carry_r, carry_nxt;
  cldq_slot_t          hit_r, hit_nxt;
  logic                ins_r, ins_nxt;
  logic                up_r, up_nxt;
  logic                wrapped_r, wrapped_nxt;
  logic [CYL_BITS-1:0] prev_r, prev_nxt;
  logic                full_r, full_nxt;

  logic             at_end;
  logic             is_remove;
  logic             wrap_now;
  logic             place;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] idx_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    cyl_r     <= cyl_nxt;
    pid_r     <= pid_nxt;
    idx_r     <= idx_nxt;
    carry_r   <= carry_nxt;
    hit_r     <= hit_nxt;
    ins_r     <= ins_nxt;
    up_r      <= up_nxt;
    wrapped_r <= wrapped_nxt;
    prev_r    <= prev_nxt;
    full_r    <= full_nxt;
  end

  assign idx_inc   = idx_r + CNT_W'(1);
  assign idx_dec   = idx_r - CNT_W'(1);
  assign is_remove = (op_r == CMD_DEQ) || (op_r == CMD_KILL);
  assign at_end    = (idx_r == count_r) || (op_r == CMD_NOP) || full_r;
  assign wrap_now  = wrapped_r || (ram_rdata.cyl < prev_r);
  assign place     = up_r ? (wrap_now || (ram_rdata.cyl > cyl_r))
                          : (wrap_now && (ram_rdata.cyl > cyl_r));

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    cyl_nxt     = cyl_r;
    pid_nxt     = pid_r;
    idx_nxt     = idx_r;
    count_nxt   = count_r;
    carry_nxt   = carry_r;
    hit_nxt     = hit_r;
    ins_nxt     = ins_r;
    up_nxt      = up_r;
    wrapped_nxt = wrapped_r;
    prev_nxt    = prev_r;
    full_nxt    = full_r;
    in_stall    = 1'b1;
    res_valid   = 1'b0;
    ram_req     = '0;

    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt     = S_SCAN;
          op_nxt        = cldq_cmd_e'(in_data.command);
          cyl_nxt       = cyl_from_field(in_data.request_cylinder);
          pid_nxt       = in_data.request_pid;
          carry_nxt.cyl = cyl_from_field(in_data.request_cylinder);
          carry_nxt.pid = in_data.request_pid;
          idx_nxt       = '0;
          ins_nxt       = 1'b0;
          wrapped_nxt   = 1'b0;
          full_nxt      = (cldq_cmd_e'(in_data.command) == CMD_ENQ)
                          && (count_r == CNT_W'(DEPTH));
          ram_req.re    = 1'b1;
          ram_req.raddr = '0;
        end
      end
      S_SCAN: begin
        if (at_end) begin
          if (res_ok) begin
            res_valid = 1'b1;
            state_nxt = S_IDLE;
            if ((op_r == CMD_ENQ) && !full_r) begin
              // The last carried slot lands one past the old tail.
              ram_req.we    = 1'b1;
              ram_req.waddr = idx_r[IDX_W-1:0];
              ram_req.wdata = carry_r;
              count_nxt     = count_r + CNT_W'(1);
            end else if (is_remove && ins_r) begin
              count_nxt = count_r - CNT_W'(1);
            end
          end
        end else begin
          idx_nxt       = idx_inc;
          ram_req.re    = 1'b1;
          ram_req.raddr = idx_inc[IDX_W-1:0];
          if (op_r == CMD_ENQ) begin
            if (ins_r) begin
              ram_req.we    = 1'b1;
              ram_req.waddr = idx_r[IDX_W-1:0];
              ram_req.wdata = carry_r;
              carry_nxt     = ram_rdata;
            end else if (idx_r == '0) begin
              up_nxt   = cyl_r > ram_rdata.cyl;
              prev_nxt = ram_rdata.cyl;
            end else begin
              wrapped_nxt = wrap_now;
              prev_nxt    = ram_rdata.cyl;
              if (place) begin
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_r[IDX_W-1:0];
                ram_req.wdata = carry_r;
                carry_nxt     = ram_rdata;
                ins_nxt       = 1'b1;
              end
            end
          end else begin
            if (ins_r) begin
              // Close the gap: each later slot moves down by one.
              ram_req.we    = 1'b1;
              ram_req.waddr = idx_dec[IDX_W-1:0];
              ram_req.wdata = ram_rdata;
            end else if ((op_r == CMD_DEQ) || (ram_rdata.pid == pid_r)) begin
              ins_nxt = 1'b1;
              hit_nxt = ram_rdata;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_data.occupancy = count_to_field(count_nxt);
    if (full_r) begin
      res_data.status = ST_FULL;
    end else if (is_remove && !ins_r) begin
      res_data.status = ST_MISS;
    end else begin
      res_data.status = ST_OK;
    end
    if (is_remove && ins_r) begin
      res_data.out_pid      = hit_r.pid;
      res_data.out_cylinder = cyl_to_field(hit_r.cyl);
    end else begin
      res_data.out_pid      = '0;
      res_data.out_cylinder = '0;
    end
  end

  a_no_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
    else $error("slot written and read at the same address");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above queue depth");

  a_count_only_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    !res_valid |=> $stable(count_r))
    else $error("entry count changed without a finished transaction");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_SCAN))
    else $error("accepted transaction did not start a scan");

  a_done_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (state_r == S_IDLE) && !$past(in_valid && !in_stall))
    else $error("result produced outside a running scan");

endmodule

`default_nettype wire

// File: design/c_look_disk_request_queue_top.sv
`default_nettype none

// C-LOOK disk request queue.
// Input channel (in_valid, in_stall, in_data): each transaction carries a
// command (enqueue, dequeue head, kill by process id), a cylinder and a
// process id. Output channel (out_valid, out_stall, out_data): exactly one
// result per input transaction, in order, with status, the removed request
// and the occupancy after the command.
// The requests live in one synchronous slot RAM. A command walks the queue
// from the head, one slot per cycle, and moves slots up or down in the same
// pass; a no-op or a refused enqueue skips the walk. The walk goes over the
// RAM's single read port; a new transaction is taken once the previous walk
// ends, even while its result still waits in the output register.
// When out_stall holds a result, a finished walk waits until the output
// register is free. Reset (rst_n low, synchronous) empties the queue and
// drops any pending result; slot contents are not cleared.
module c_look_disk_request_queue_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire cldq_pkg::cldq_in_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output cldq_pkg::cldq_out_t       out_data
);

  import cldq_pkg::*;

  cldq_ram_req_t ram_req;
  cldq_slot_t    ram_rdata;
  logic          res_valid;
  cldq_out_t     res_data;
  logic          res_ok;
  logic          out_valid_r, out_valid_nxt;
  cldq_out_t     out_data_r, out_data_nxt;

  cldq_slot_ram #(
    .DATA_W (SLOT_W),
    .DEPTH  (DEPTH),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  cldq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_ok    (res_ok),
    .res_valid (res_valid),
    .res_data  (res_data),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  assign res_ok = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
